// ----- sv/slsh_pkg.sv -----
// ----------------------------------------------------------------------------
// slsh_pkg
// Shared types and salt tables for the salted lane-sum digest.
// ----------------------------------------------------------------------------
package slsh_pkg;

  localparam int LANES  = 20;
  localparam int IDX_W  = $clog2(LANES);
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  localparam logic [LEN_W-1:0]  SALT_LEN = 7'd40;
  localparam logic [BYTE_W-1:0] PRE_SUM  = 8'd51;
  localparam logic [BYTE_W-1:0] POST_SUM = 8'd232;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LANES - 1);

  // prefix salt folded per lane: pre[i] + pre[i+20]
  localparam logic [BYTE_W-1:0] PRE_PAIR [LANES] = '{
    8'd216, 8'd151, 8'd127, 8'd192, 8'd130, 8'd231, 8'd134, 8'd241, 8'd161, 8'd197,
    8'd180, 8'd150, 8'd198, 8'd174, 8'd221, 8'd216, 8'd172, 8'd172, 8'd180, 8'd192
  };

  // suffix salt folded by offset from the lane position: post[j] + post[j+20]
  localparam logic [BYTE_W-1:0] POST_PAIR [LANES] = '{
    8'd124, 8'd169, 8'd149, 8'd203, 8'd184, 8'd225, 8'd191, 8'd193, 8'd140, 8'd191,
    8'd166, 8'd150, 8'd186, 8'd169, 8'd171, 8'd194, 8'd179, 8'd163, 8'd181, 8'd232
  };

  localparam logic [LEN_W-1:0] MUL_A [LANES] = '{
    7'd86, 7'd0, 7'd0, 7'd36, 7'd58, 7'd38, 7'd7, 7'd0, 7'd87, 7'd67,
    7'd6, 7'd2, 7'd5, 7'd88, 7'd84, 7'd0, 7'd0, 7'd0, 7'd0, 7'd19
  };

  localparam logic [LEN_W-1:0] MUL_B [LANES] = '{
    7'd5, 7'd0, 7'd0, 7'd17, 7'd8, 7'd8, 7'd6, 7'd67, 7'd12, 7'd0,
    7'd2, 7'd0, 7'd17, 7'd38, 7'd0, 7'd46, 7'd1, 7'd0, 7'd8, 7'd1
  };

  typedef struct packed {
    logic             hop;      // a byte enters this cycle
    logic             fin;      // last word taken: capture and restart
    logic [IDX_W-1:0] pos_fin;  // lane position after this cycle's byte
  } lane_ctl_t;

endpackage

// ----- sv/slsh_lane_cell.sv -----
// ----------------------------------------------------------------------------
// slsh_lane_cell
// One lane accumulator of the ring; the position token hops to the next cell.
// ----------------------------------------------------------------------------
module slsh_lane_cell #(
  parameter int LANE_ID = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slsh_pkg::lane_ctl_t        ctl,
  input  logic [slsh_pkg::BYTE_W-1:0] data_byte,
  input  logic                       tok_in,
  output logic                       tok_out,
  output logic [slsh_pkg::BYTE_W-1:0] fin_sum
);
  import slsh_pkg::*;

  localparam logic [IDX_W-1:0] ID = IDX_W'(LANE_ID);

  logic              tok_r, tok_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] upd;
  logic [IDX_W-1:0]  ofs;

  assign upd     = sum_r + ((tok_r && ctl.hop) ? data_byte : '0);
  // wraps mod 32 but the true offset is always below LANES
  assign ofs     = (ID >= ctl.pos_fin) ? (ID - ctl.pos_fin)
                                       : (ID + IDX_W'(LANES) - ctl.pos_fin);
  assign fin_sum = upd + POST_PAIR[ofs];
  assign tok_out = tok_r;

  always_comb begin
    priority if (ctl.fin) begin
      tok_nxt = (LANE_ID == 0);
      sum_nxt = PRE_PAIR[LANE_ID];
    end else begin
      tok_nxt = ctl.hop ? tok_in : tok_r;
      sum_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= (LANE_ID == 0);
      sum_r <= PRE_PAIR[LANE_ID];
    end else begin
      tok_r <= tok_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- sv/slsh_tap_cell.sv -----
// ----------------------------------------------------------------------------
// slsh_tap_cell
// One stage of the digest drain chain: parallel load, shift toward the head.
// ----------------------------------------------------------------------------
module slsh_tap_cell (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        shift,
  input  logic [slsh_pkg::BYTE_W-1:0] load_val,
  input  logic [slsh_pkg::BYTE_W-1:0] shift_in,
  output logic [slsh_pkg::BYTE_W-1:0] val
);
  import slsh_pkg::*;

  logic [BYTE_W-1:0] val_r, val_nxt;

  always_comb begin
    priority if (load) begin
      val_nxt = load_val;
    end else if (shift) begin
      val_nxt = shift_in;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- sv/salted_lane_sum_hash.sv -----
// ----------------------------------------------------------------------------
// salted_lane_sum_hash
// Salted 20-lane byte-sum digest, one message byte per word in, 20 bytes out.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              payload
//  in_*         in   in_valid / in_ready    in_data_byte, in_is_last, in_no_data
//  out_*        out  out_valid / out_ready  out_digest_byte, out_byte_index,
//                                           out_last_byte
//
//  One input word per cycle while in_ready is high; a byte lands in the
//  token-holding lane cell. A last word loads the drain chain; its 20 digest
//  words follow, one per cycle while out_ready is high. A last word stalls on a
//  pending digest unless its final word is taken; others go in during the drain.
//  Reset (rst_n low, synchronous) restores the salted state.
// ----------------------------------------------------------------------------
module salted_lane_sum_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slsh_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                         in_is_last,
  input  logic                         in_no_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slsh_pkg::BYTE_W-1:0]  out_digest_byte,
  output logic [slsh_pkg::IDX_W-1:0]   out_byte_index,
  output logic                         out_last_byte
);
  import slsh_pkg::*;

  logic take, pop, out_free;
  logic hop, fin;
  lane_ctl_t ctl;

  logic [IDX_W-1:0]  pos_r, pos_upd;
  logic [BYTE_W-1:0] sum_r, sum_upd;
  logic [LEN_W-1:0]  len_r, len_upd;

  logic [LANES-1:0]  tok;
  logic [BYTE_W-1:0] fin_lane [LANES];
  logic [BYTE_W-1:0] tap [LANES];

  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] os_r;
  logic [LEN_W-1:0]  ol_r;

  logic [2*LEN_W-1:0]  prod_a, prod_b;
  logic [2*BYTE_W-1:0] prod_m;

  assign pop      = ov_r && out_ready;
  assign out_free = !ov_r || (out_ready && (idx_r == LAST_IDX));
  assign in_ready = !in_is_last || out_free;
  assign take     = in_valid && in_ready;

  assign hop = take && !in_no_data;
  assign fin = take && in_is_last;
  assign ctl = '{hop: hop, fin: fin, pos_fin: pos_upd};

  assign pos_upd = !hop ? pos_r : ((pos_r == LAST_IDX) ? '0 : pos_r + 1'b1);
  assign sum_upd = sum_r + (hop ? in_data_byte : '0);
  assign len_upd = len_r + LEN_W'(hop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= PRE_SUM;
      len_r <= SALT_LEN;
    end else if (fin) begin
      pos_r <= '0;
      sum_r <= PRE_SUM;
      len_r <= SALT_LEN;
    end else begin
      pos_r <= pos_upd;
      sum_r <= sum_upd;
      len_r <= len_upd;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    slsh_lane_cell #(.LANE_ID(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .data_byte (in_data_byte),
      .tok_in    (tok[(k + LANES - 1) % LANES]),
      .tok_out   (tok[k]),
      .fin_sum   (fin_lane[k])
    );

    slsh_tap_cell u_tap (
      .clk      (clk),
      .load     (fin),
      .shift    (pop),
      .load_val (fin_lane[k]),
      .shift_in ((k == LANES - 1) ? '0 : tap[(k + 1) % LANES]),
      .val      (tap[k])
    );
  end

  always_comb begin
    priority if (fin) begin
      ov_nxt  = 1'b1;
      idx_nxt = '0;
    end else if (pop) begin
      ov_nxt  = (idx_r != LAST_IDX);
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end else begin
      ov_nxt  = ov_r;
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      os_r <= sum_upd + POST_SUM;
      ol_r <= len_upd + SALT_LEN;
    end
  end

  assign prod_a = MUL_A[idx_r] * ol_r;
  assign prod_b = MUL_B[idx_r] * os_r[LEN_W-1:0];
  assign prod_m = os_r * tap[0];

  assign out_valid       = ov_r;
  assign out_digest_byte = BYTE_W'(prod_a[LEN_W-1:0]) + BYTE_W'(prod_b[LEN_W-1:0])
                         + prod_m[BYTE_W-1:0];
  assign out_byte_index  = idx_r;
  assign out_last_byte   = (idx_r == LAST_IDX);

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tok))
    else $error("lane token not one-hot");

  a_tok_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tok[pos_r] && (pos_r <= LAST_IDX))
    else $error("lane token and position disagree");

  a_fin_start: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (ov_r && (idx_r == '0)))
    else $error("digest did not start at lane zero");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!ov_r || (pop && out_last_byte)))
    else $error("digest captured over a pending one");

endmodule
